// ----- rtl/mlfd_pkg.sv -----
package mlfd_pkg;

    localparam int unsigned MAX_FRAME_DEF = 8192;

    localparam logic [15:0] MARK_START   = 16'h3E92;
    localparam logic [15:0] MARK_END     = 16'h3EEC;
    localparam logic [16:0] EXT_OVERHEAD = 17'd10;
    localparam logic [16:0] STD_OVERHEAD = 17'd8;

    localparam logic [2:0] HDR_STD_BYTES = 3'd4;
    localparam logic [2:0] HDR_EXT_BYTES = 3'd6;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EXT     = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_END = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;

    localparam int unsigned TDATA_W = 32;
    localparam int unsigned TUSER_W = 2;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_HEAD  = 3'd1,
        PH_PAY   = 3'd2,
        PH_EXT   = 3'd3,
        PH_TRAIL = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] packet_id;
        logic [1:0]  item_kind;
        logic [1:0]  frame_status;
        logic        frame_end;
    } t_result;

endpackage

// ----- rtl/mlfd_parser.sv -----
module mlfd_parser
    import mlfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_prev, n_prev;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [15:0] r_frame_len, n_frame_len;
    logic [15:0] r_id, n_id;
    logic [15:0] r_ext_len, n_ext_len;
    logic [15:0] r_seen, n_seen;
    logic        r_ext_mode;

    logic [15:0] seen_inc;
    logic [16:0] overhead;
    logic        hdr_done;
    logic        len_bad;
    logic [15:0] pay_len;

    always_comb begin
        n_phase     = r_phase;
        n_prev      = r_prev;
        n_hdr_cnt   = r_hdr_cnt;
        n_frame_len = r_frame_len;
        n_id        = r_id;
        n_ext_len   = r_ext_len;
        n_seen      = r_seen;
        o_res_valid = 1'b0;
        o_res       = '0;
        seen_inc    = r_seen + 16'd1;
        overhead    = STD_OVERHEAD;
        hdr_done    = 1'b0;
        len_bad     = 1'b0;
        pay_len     = '0;

        case (r_phase)
            PH_HEAD: begin
                case (r_hdr_cnt)
                    3'd0: n_frame_len = {8'h00, i_rx_byte};
                    3'd1: n_frame_len[15:8] = i_rx_byte;
                    3'd2: n_id = {8'h00, i_rx_byte};
                    3'd3: n_id[15:8] = i_rx_byte;
                    3'd4: n_ext_len = {8'h00, i_rx_byte};
                    default: n_ext_len[15:8] = i_rx_byte;
                endcase
                n_hdr_cnt = r_hdr_cnt + 3'd1;
                hdr_done  = n_hdr_cnt >= (r_ext_mode ? HDR_EXT_BYTES : HDR_STD_BYTES);
                if (!r_ext_mode) begin
                    n_ext_len = '0;
                end
                overhead = r_ext_mode ? ({1'b0, n_ext_len} + EXT_OVERHEAD) : STD_OVERHEAD;
                len_bad  = r_ext_mode ? ({1'b0, n_frame_len} <= overhead)
                                      : ({1'b0, n_frame_len} < overhead);
                if (n_frame_len > 16'(MAX_FRAME)) begin
                    len_bad = 1'b1;
                end
                pay_len = n_frame_len - overhead[15:0];
                if (!hdr_done) begin
                    if (!r_ext_mode) begin
                        n_ext_len = r_hdr_cnt == 3'd4 ? {8'h00, i_rx_byte} : r_ext_len;
                    end
                end else if (len_bad) begin
                    o_res_valid        = 1'b1;
                    o_res.packet_id    = n_id;
                    o_res.item_kind    = KIND_STATUS;
                    o_res.frame_status = ST_BAD_LEN;
                    o_res.frame_end    = 1'b1;
                    n_phase   = PH_HUNT;
                    n_prev    = '0;
                    n_hdr_cnt = '0;
                    n_seen    = '0;
                end else begin
                    n_frame_len = pay_len;
                    n_seen      = '0;
                    if (pay_len != 16'd0) begin
                        n_phase = PH_PAY;
                    end else if (n_ext_len != 16'd0) begin
                        n_phase = PH_EXT;
                    end else begin
                        n_phase = PH_TRAIL;
                    end
                end
            end
            PH_PAY: begin
                o_res_valid     = 1'b1;
                o_res.out_byte  = i_rx_byte;
                o_res.packet_id = r_id;
                o_res.item_kind = KIND_PAYLOAD;
                n_seen = seen_inc;
                if (seen_inc >= r_frame_len) begin
                    n_seen  = '0;
                    n_phase = (r_ext_len != 16'd0) ? PH_EXT : PH_TRAIL;
                end
            end
            PH_EXT: begin
                o_res_valid     = 1'b1;
                o_res.out_byte  = i_rx_byte;
                o_res.packet_id = r_id;
                o_res.item_kind = KIND_EXT;
                n_seen = seen_inc;
                if (seen_inc >= r_ext_len) begin
                    n_seen  = '0;
                    n_phase = PH_TRAIL;
                end
            end
            PH_TRAIL: begin
                if (r_seen == 16'd0) begin
                    n_prev = i_rx_byte;
                    n_seen = 16'd1;
                end else begin
                    o_res_valid        = 1'b1;
                    o_res.packet_id    = r_id;
                    o_res.item_kind    = KIND_STATUS;
                    o_res.frame_status = ({i_rx_byte, r_prev} == MARK_END) ? ST_OK : ST_BAD_END;
                    o_res.frame_end    = 1'b1;
                    n_phase   = PH_HUNT;
                    n_prev    = '0;
                    n_hdr_cnt = '0;
                    n_seen    = '0;
                end
            end
            default: begin
                if ({i_rx_byte, r_prev} == MARK_START) begin
                    n_phase     = PH_HEAD;
                    n_hdr_cnt   = '0;
                    n_frame_len = '0;
                    n_id        = '0;
                    n_ext_len   = '0;
                    n_seen      = '0;
                    n_prev      = '0;
                end else begin
                    n_phase = PH_HUNT;
                    n_prev  = i_rx_byte;
                end
            end
        endcase

        if (!i_accept) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_prev      <= '0;
            r_hdr_cnt   <= '0;
            r_frame_len <= '0;
            r_id        <= '0;
            r_ext_len   <= '0;
            r_seen      <= '0;
            r_ext_mode  <= 1'b0;
        end else begin
            if (i_accept) begin
                r_phase     <= n_phase;
                r_prev      <= n_prev;
                r_hdr_cnt   <= n_hdr_cnt;
                r_frame_len <= n_frame_len;
                r_id        <= n_id;
                r_ext_len   <= n_ext_len;
                r_seen      <= n_seen;
            end
            if (i_cfg_we) begin
                r_ext_mode <= i_cfg_data;
            end
        end
    end

    a_hdr_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_cnt <= HDR_EXT_BYTES)
        else $error("header count out of range");

    a_status_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.item_kind == KIND_STATUS) |=> r_phase == PH_HUNT)
        else $error("status item not followed by hunting");

    a_pay_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAY |-> r_seen < r_frame_len)
        else $error("payload count past section length");

endmodule

// ----- rtl/mlfd_out_skid.sv -----
module mlfd_out_skid
    import mlfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_valid;
    logic    r_sk_valid;
    t_result r_data;
    t_result r_sk_data;
    logic    pop;

    assign pop     = r_valid && i_ready;
    assign o_ready = !r_sk_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (pop) begin
            if (r_sk_valid) begin
                r_data     <= r_sk_data;
                r_sk_valid <= 1'b0;
            end else if (i_push) begin
                r_data <= i_data;
            end else begin
                r_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_valid) begin
                r_data  <= i_data;
                r_valid <= 1'b1;
            end else begin
                r_sk_data  <= i_data;
                r_sk_valid <= 1'b1;
            end
        end
    end

    a_spare_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_valid)
        else $error("spare entry held without main entry");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> !i_push)
        else $error("transfer pushed into full buffer");

endmodule

// ----- rtl/marker_length_frame_deframer.sv -----
// Channel   Direction  Handshake                  Payload
// s         in         i_s_tvalid / o_s_tready    i_s_tdata: rx_byte
// m         out        o_m_tvalid / i_m_tready    o_m_tdata, o_m_tuser, o_m_tlast
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_data: extended_mode
//
// One byte per cycle while the output buffer has room; each byte is decoded in the cycle it is taken.
// A result is registered in the output buffer before it reaches o_m.
// i_rst_n is synchronous: hunting for the start marker, normal header mode.
// A two-entry output buffer keeps o_s_tready high while o_m stalls, until its spare entry is full.
module marker_length_frame_deframer
    import mlfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,   // [7:0] rx_byte
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,   // [7:0] out_byte, [23:8] packet_id,
                                            // [25:24] frame_status, [31:26] zero
    output logic [TUSER_W-1:0] o_m_tuser,   // [1:0] item_kind
    output logic               o_m_tlast,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign accept      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    mlfd_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_rx_byte   (i_s_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mlfd_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (out_res)
    );

    assign o_m_tdata = {6'd0, out_res.frame_status, out_res.packet_id, out_res.out_byte};
    assign o_m_tuser = out_res.item_kind;
    assign o_m_tlast = out_res.frame_end;

endmodule

// ----- bench/mlfd_frame_checker.sv -----
`timescale 1ns / 100ps

module mlfd_frame_checker
    import mlfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [7:0]         i_s_tdata,   // [7:0] rx_byte
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [TDATA_W-1:0] i_m_tdata,   // [7:0] out_byte, [23:8] packet_id,
                                            // [25:24] frame_status, [31:26] zero
    input  logic [TUSER_W-1:0] i_m_tuser,   // [1:0] item_kind
    input  logic               i_m_tlast,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    t_phase      phase;
    logic        ext_mode;
    logic [7:0]  prev_byte;
    logic [2:0]  hdr_count;
    logic [15:0] frame_len;
    logic [15:0] cur_id;
    logic [15:0] ext_len;
    logic [15:0] seen;
    t_result     expected_items[$];
    t_result     want;
    int          fail_count = 0;
    int          results_seen = 0;

    assign o_fail_count = fail_count;

    task automatic report(input string msg);
        $display("%0t ns: result %0d: %s", $time, results_seen, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] exp_val);
        if (got !== exp_val)
            report($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, exp_val));
    endtask

    task automatic push_item(input logic [7:0] b, input logic [1:0] kind,
                             input logic [1:0] st);
        t_result r;
        r.out_byte     = b;
        r.packet_id    = cur_id;
        r.item_kind    = kind;
        r.frame_status = st;
        r.frame_end    = (kind == KIND_STATUS);
        expected_items.push_back(r);
    endtask

    task automatic return_to_hunt();
        phase     = PH_HUNT;
        prev_byte = '0;
        hdr_count = '0;
        seen      = '0;
    endtask

    task automatic decode_rx_byte(input logic [7:0] b);
        logic [2:0] need;
        logic       bad;
        case (phase)
            PH_HEAD: begin
                case (hdr_count)
                    3'd0: frame_len = {8'h00, b};
                    3'd1: frame_len[15:8] = frame_len[15:8] | b;
                    3'd2: cur_id = {8'h00, b};
                    3'd3: cur_id[15:8] = cur_id[15:8] | b;
                    3'd4: ext_len = {8'h00, b};
                    default: ext_len[15:8] = ext_len[15:8] | b;
                endcase
                hdr_count = hdr_count + 3'd1;
                need = ext_mode ? HDR_EXT_BYTES : HDR_STD_BYTES;
                if (hdr_count >= need) begin
                    if (ext_mode) begin
                        bad = {1'b0, frame_len} <= EXT_OVERHEAD + {1'b0, ext_len};
                    end else begin
                        ext_len = '0;
                        bad = {1'b0, frame_len} < STD_OVERHEAD;
                    end
                    if (frame_len > MAX_FRAME)
                        bad = 1'b1;
                    if (bad) begin
                        push_item(8'h00, KIND_STATUS, ST_BAD_LEN);
                        return_to_hunt();
                    end else begin
                        if (ext_mode)
                            frame_len = 16'(frame_len - EXT_OVERHEAD - ext_len);
                        else
                            frame_len = 16'(frame_len - STD_OVERHEAD);
                        seen = '0;
                        if (frame_len != 0)
                            phase = PH_PAY;
                        else if (ext_len != 0)
                            phase = PH_EXT;
                        else
                            phase = PH_TRAIL;
                    end
                end
            end
            PH_PAY: begin
                push_item(b, KIND_PAYLOAD, ST_OK);
                seen = seen + 16'd1;
                if (seen >= frame_len) begin
                    seen  = '0;
                    phase = (ext_len != 0) ? PH_EXT : PH_TRAIL;
                end
            end
            PH_EXT: begin
                push_item(b, KIND_EXT, ST_OK);
                seen = seen + 16'd1;
                if (seen >= ext_len) begin
                    seen  = '0;
                    phase = PH_TRAIL;
                end
            end
            PH_TRAIL: begin
                if (seen == 0) begin
                    prev_byte = b;
                    seen      = 16'd1;
                end else begin
                    push_item(8'h00, KIND_STATUS,
                              ({b, prev_byte} == MARK_END) ? ST_OK : ST_BAD_END);
                    return_to_hunt();
                end
            end
            default: begin
                if ({b, prev_byte} == MARK_START) begin
                    phase     = PH_HEAD;
                    hdr_count = '0;
                    frame_len = '0;
                    cur_id    = '0;
                    ext_len   = '0;
                    seen      = '0;
                    prev_byte = '0;
                end else begin
                    phase     = PH_HUNT;
                    prev_byte = b;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ext_mode  = 1'b0;
            frame_len = '0;
            cur_id    = '0;
            ext_len   = '0;
            return_to_hunt();
            expected_items.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                results_seen++;
                if (expected_items.size() == 0) begin
                    report($sformatf("transfer with nothing predicted, tdata 0x%0h",
                                     i_m_tdata));
                end else begin
                    want = expected_items.pop_front();
                    compare_field("out_byte", 16'(i_m_tdata[7:0]), 16'(want.out_byte));
                    compare_field("packet_id", i_m_tdata[23:8], want.packet_id);
                    compare_field("frame_status", 16'(i_m_tdata[25:24]),
                                  16'(want.frame_status));
                    compare_field("tdata padding", 16'(i_m_tdata[31:26]), 16'h0000);
                    compare_field("item_kind", 16'(i_m_tuser), 16'(want.item_kind));
                    compare_field("frame_end", 16'(i_m_tlast), 16'(want.frame_end));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                ext_mode = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                decode_rx_byte(i_s_tdata);
        end
        o_pending <= expected_items.size();
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    import mlfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = 8'h00;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;
    logic               m_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_data  = 1'b0;

    int   fail_count;
    int   pending;
    int   sent        = 0;
    int   idle_cycles = 0;
    logic ext_sel     = 1'b0;
    logic quiet       = 1'b0;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;

    always #4 clk = ~clk;

    marker_length_frame_deframer #(
        .MAX_FRAME(MAX_FRAME_DEF)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    mlfd_frame_checker #(
        .MAX_FRAME(MAX_FRAME_DEF)
    ) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // hold off once for a long stretch so the input side fills and stalls
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 30);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    task automatic send_word(input logic [15:0] w);
        send_byte(w[7:0]);
        send_byte(w[15:8]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ext_sel = m;
    endtask

    // body < 0: the header is rejected, so no body and no trailer follow
    task automatic send_frame(input logic [15:0] len, input logic [15:0] id,
                              input logic [15:0] xlen, input int body,
                              input logic [15:0] trailer);
        send_word(MARK_START);
        send_word(len);
        send_word(id);
        if (ext_sel)
            send_word(xlen);
        if (body >= 0) begin
            repeat (body) send_byte(8'($urandom_range(255)));
            send_word(trailer);
        end
    endtask

    task automatic random_traffic(input int goal);
        int          stop;
        int          pick;
        int          pay;
        logic [15:0] xlen;
        logic [15:0] len;
        logic [15:0] trailer;
        stop = sent + goal;
        while (sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(99) < 30) ? 8'h92 : 8'($urandom_range(255)));
            end else if (pick < 18) begin
                xlen = 16'($urandom_range(65535));
                if ($urandom_range(1) == 1)
                    len = 16'($urandom_range(MAX_FRAME_DEF + 1, 65535));
                else if (ext_sel)
                    len = 16'($urandom_range((xlen > 16'd65525) ? 65535 : xlen + 10));
                else
                    len = 16'($urandom_range(7));
                send_frame(len, 16'($urandom_range(65535)), xlen, -1, 16'h0000);
            end else begin
                pay = ($urandom_range(9) == 0) ? $urandom_range(17, 200) : $urandom_range(16);
                if (ext_sel) begin
                    xlen = 16'(($urandom_range(3) == 0) ? $urandom_range(40)
                                                         : $urandom_range(6));
                    if (pay == 0)
                        pay = 1;
                    len = 16'(pay + 10 + xlen);
                end else begin
                    xlen = 16'h0000;
                    len  = 16'(pay + 8);
                end
                if ($urandom_range(9) == 0)
                    trailer = ($urandom_range(1) == 1) ? 16'h3FEC : 16'($urandom_range(65535));
                else
                    trailer = MARK_END;
                send_frame(len, 16'($urandom_range(65535)), xlen, pay + xlen, trailer);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_mode(1'b0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h3E);
        send_byte(8'h92);
        send_frame(16'd8, 16'hFFFF, 16'h0000, 0, MARK_END);
        send_frame(16'd7, 16'h0000, 16'h0000, -1, 16'h0000);
        send_frame(16'd8193, 16'h1234, 16'h0000, -1, 16'h0000);
        send_frame(16'd9, 16'h00A5, 16'h0000, 1, 16'h3FEC);

        set_mode(1'b1);
        send_frame(16'd11, 16'h8001, 16'd0, 1, MARK_END);
        send_frame(16'd12, 16'h8002, 16'd2, 2, MARK_END);
        send_frame(16'd10, 16'h8003, 16'd0, -1, 16'h0000);
        send_frame(16'hFFFF, 16'h8004, 16'hFFFF, -1, 16'h0000);

        // switch header size part way through a header
        send_word(MARK_START);
        send_word(16'd11);
        send_word(16'h5A5A);
        set_mode(1'b0);
        send_byte(8'h00);
        repeat (3) send_byte(8'($urandom_range(255)));
        send_word(MARK_END);
        send_word(MARK_START);
        send_word(16'd14);
        set_mode(1'b1);
        send_word(16'hC3C3);
        send_word(16'd1);
        repeat (4) send_byte(8'($urandom_range(255)));
        send_word(MARK_END);

        set_mode(1'b0);
        hold_req = 1'b1;
        random_traffic(450);

        set_mode(1'b1);
        quiet = 1'b1;
        random_traffic(250);
        quiet = 1'b0;
        random_traffic(250);

        set_mode(1'b0);
        random_traffic(400);

        set_mode(1'b1);
        random_traffic(350);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
